// ===== rtl/gbte_pkg.sv =====
// Shared constants, key codes and beat types for the gap buffer text edit engine.
`timescale 1ns / 1ps
package gbte_pkg;

   localparam int BUF_BYTES  = 8192;
   localparam int ADDR_W     = $clog2(BUF_BYTES);
   localparam int PTR_W      = ADDR_W + 1;
   localparam int WRAP_WIDTH = 75;
   localparam int PAGE_LINES = 24;
   localparam int PAGE_W     = $clog2(PAGE_LINES);
   localparam int LINE_W     = 14;
   localparam int WC_W       = 7;
   localparam int POS_W      = 13;
   localparam int CNT_W      = PTR_W;

   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAN = 2'd2;

   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_SP     = 8'd32;
   localparam logic [7:0] CH_LAST   = 8'd126;
   localparam logic [7:0] KEY_BS    = 8'd8;
   localparam logic [7:0] KEY_TAB   = 8'd9;
   localparam logic [7:0] KEY_RET   = 8'd13;
   localparam logic [7:0] KEY_DEL   = 8'd127;
   localparam logic [7:0] KEY_PGUP  = 8'h8A;
   localparam logic [7:0] KEY_PGDN  = 8'h8B;
   localparam logic [7:0] KEY_RIGHT = 8'h8E;
   localparam logic [7:0] KEY_UP    = 8'h8F;
   localparam logic [7:0] KEY_END   = 8'h9A;
   localparam logic [7:0] KEY_HOME  = 8'h9B;
   localparam logic [7:0] KEY_LEFT  = 8'h9E;
   localparam logic [7:0] KEY_DOWN  = 8'h9F;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       key_code;
      logic [POS_W-1:0] read_position;
   } gbte_req_type;

   typedef struct packed {
      logic [7:0]        read_byte;
      logic              read_valid;
      logic [LINE_W-1:0] line_number;
      logic [LINE_W-1:0] column_number;
      logic [WC_W-1:0]   wrapped_column;
      logic [LINE_W-1:0] wrapped_line;
      logic [LINE_W-1:0] free_bytes;
      logic              modified;
   } gbte_rsp_type;

   typedef struct packed {
      logic start;
      logic take;
   } gbte_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } gbte_status_type;

endpackage

// ===== rtl/gap_buffer_text_edit_engine_top.sv =====
// Top level: request and response handshakes around the edit sequencer.
// Left/right moves, line, page, home and end walks and line-start scans all step one byte at a time.
// One beat at a time; the next request is taken once the result is in the output register.
// Reset: synchronous; empty document, cursor at origin, modified set, no RAM clearing pass.
`timescale 1ns / 1ps
module gap_buffer_text_edit_engine_top
   import gbte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  gbte_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output gbte_rsp_type rsp_payload
);

   gbte_ctl_type    ctl;
   gbte_status_type status;
   gbte_rsp_type    result;
   logic            rsp_valid_ff;
   gbte_rsp_type    rsp_payload_ff;

   assign req_ready = status.idle;
   assign ctl.start = req_valid && status.idle;
   assign ctl.take  = status.done && (!rsp_valid_ff || rsp_ready);

   gbte_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .req    (req_payload),
      .status (status),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.take) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/gbte_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module gbte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gbte_engine.sv =====
// Edit sequencer: gap pointers, cursor position and key handling around the text RAM.
`timescale 1ns / 1ps
module gbte_engine
   import gbte_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  gbte_ctl_type    ctl,
   input  gbte_req_type    req,
   output gbte_status_type status,
   output gbte_rsp_type    result
);

   typedef enum logic [5:0] {
      S_IDLE, S_DISP, S_RD_A, S_RD_B, S_FIN,
      S_INS, S_MR_A, S_MR_B, S_RB_A, S_RB_B, S_SC_A, S_SC_B,
      K_RET1, K_TAB1, K_PAD, K_BS1, K_BS2, K_BS3,
      K_DN0, K_DN1, K_DN2, K_UP0, K_UP1, K_UP2, K_UP3,
      K_AG1, K_AG2, K_LEND, K_HOME, K_HOME2, K_END, K_END2, K_GOAL
   } state_type;

   typedef struct packed {
      logic [LINE_W-1:0] lc;
      logic [LINE_W-1:0] cc;
      logic [WC_W-1:0]   wc;
      logic [LINE_W-1:0] wl;
   } pos_type;

   function automatic pos_type ins_step(pos_type p, logic [7:0] ch);
      pos_type r;
      r    = p;
      r.cc = p.cc + 1'b1;
      if (ch == CH_NL) begin
         r.cc = '0;
         r.lc = p.lc + 1'b1;
         r.wc = '0;
         r.wl = p.wl + 1'b1;
      end else if (p.wc == WC_W'(WRAP_WIDTH - 1)) begin
         r.wc = '0;
         r.wl = p.wl + 1'b1;
      end else begin
         r.wc = p.wc + 1'b1;
      end
      return r;
   endfunction

   state_type        state_ff, state_in, ret_ff, ret_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       key_ff, key_in;
   logic [POS_W-1:0] rpos_ff, rpos_in;
   logic [PTR_W-1:0] gs_ff, gs_in, ge_ff, ge_in;
   pos_type          pos_ff, pos_in;
   logic [WC_W-1:0]  goal_ff, goal_in;
   logic             chg_ff, chg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic             ml_ff, ml_in, peek_ff, peek_in, scrb_ff, scrb_in, rbnl_ff, rbnl_in;
   logic [7:0]       ch_ff, ch_in;
   logic             none_ff, none_in;
   logic [PTR_W-1:0] p_ff, p_in, dist_ff, dist_in, run_ff, run_in;
   logic [WC_W-1:0]  mod_ff, mod_in;
   logic             nonsp_ff, nonsp_in;
   logic [7:0]       rbyte_ff, rbyte_in;
   logic             rvalid_ff, rvalid_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_wa, ram_ra;
   logic [7:0]        ram_wd, rd;
   logic              scan_end, is_up;
   logic [PTR_W-1:0]  doc_len, rpos_ext, rd_ptr;

   gbte_ram #(
      .WIDTH (8),
      .DEPTH (BUF_BYTES)
   ) u_text (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (rd)
   );

   assign is_up    = (key_ff == KEY_UP) || (key_ff == KEY_PGUP);
   assign rpos_ext = PTR_W'(rpos_ff);
   assign doc_len  = gs_ff + (PTR_W'(BUF_BYTES) - ge_ff);
   assign rd_ptr   = (rpos_ext < gs_ff) ? rpos_ext : (rpos_ext - gs_ff + ge_ff);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      kind_in   = kind_ff;
      key_in    = key_ff;
      rpos_in   = rpos_ff;
      gs_in     = gs_ff;
      ge_in     = ge_ff;
      pos_in    = pos_ff;
      goal_in   = goal_ff;
      chg_in    = chg_ff;
      cnt_in    = cnt_ff;
      page_in   = page_ff;
      ml_in     = ml_ff;
      peek_in   = peek_ff;
      scrb_in   = scrb_ff;
      rbnl_in   = rbnl_ff;
      ch_in     = ch_ff;
      none_in   = none_ff;
      p_in      = p_ff;
      dist_in   = dist_ff;
      run_in    = run_ff;
      mod_in    = mod_ff;
      nonsp_in  = nonsp_ff;
      rbyte_in  = rbyte_ff;
      rvalid_in = rvalid_ff;
      ram_we    = 1'b0;
      ram_wa    = gs_ff[ADDR_W-1:0];
      ram_wd    = ch_ff;
      ram_ra    = gs_ff[ADDR_W-1:0];
      scan_end  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               kind_in  = req.kind;
               key_in   = req.key_code;
               rpos_in  = req.read_position;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            rbyte_in  = '0;
            rvalid_in = 1'b0;
            unique case (kind_ff)
               KIND_KEY: begin
                  state_in = K_GOAL;
                  ml_in    = 1'b0;
                  peek_in  = 1'b0;
                  scrb_in  = 1'b0;
                  p_in     = gs_ff;
                  dist_in  = '0;
                  mod_in   = '0;
                  run_in   = '0;
                  nonsp_in = 1'b0;
                  ret_in   = K_GOAL;
                  if (key_ff >= CH_SP && key_ff <= CH_LAST) begin
                     ch_in    = key_ff;
                     chg_in   = 1'b1;
                     state_in = S_INS;
                  end else begin
                     case (key_ff)
                        KEY_RET: begin
                           chg_in   = 1'b1;
                           ret_in   = K_RET1;
                           state_in = S_SC_A;
                        end
                        KEY_BS: begin
                           chg_in   = 1'b1;
                           ret_in   = K_BS1;
                           state_in = S_SC_A;
                        end
                        KEY_DEL: begin
                           chg_in = 1'b1;
                           if (!ge_ff[ADDR_W]) begin
                              ge_in = ge_ff + 1'b1;
                           end
                        end
                        KEY_TAB: begin
                           chg_in   = 1'b1;
                           ch_in    = CH_SP;
                           ret_in   = K_TAB1;
                           state_in = S_INS;
                        end
                        KEY_RIGHT: state_in = S_MR_A;
                        KEY_LEFT: begin
                           ml_in    = 1'b1;
                           state_in = S_RB_A;
                        end
                        KEY_DOWN: begin
                           page_in  = PAGE_W'(1);
                           state_in = K_DN0;
                        end
                        KEY_PGDN: begin
                           page_in  = PAGE_W'(PAGE_LINES - 1);
                           state_in = K_DN0;
                        end
                        KEY_UP: begin
                           page_in  = PAGE_W'(1);
                           state_in = K_UP0;
                        end
                        KEY_PGUP: begin
                           page_in  = PAGE_W'(PAGE_LINES - 1);
                           state_in = K_UP0;
                        end
                        KEY_HOME: state_in = K_HOME;
                        KEY_END:  state_in = K_END;
                        default:  state_in = K_GOAL;
                     endcase
                  end
               end
               KIND_READ:  state_in = S_RD_A;
               KIND_CLEAN: begin
                  chg_in   = 1'b0;
                  state_in = S_FIN;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_RD_A: begin
            if (rpos_ext < doc_len) begin
               ram_ra    = rd_ptr[ADDR_W-1:0];
               rvalid_in = 1'b1;
               state_in  = S_RD_B;
            end else begin
               rbyte_in = CH_NL;
               state_in = S_FIN;
            end
         end
         S_RD_B: begin
            rbyte_in = rd;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (ctl.take) begin
               state_in = S_IDLE;
            end
         end
         S_INS: begin
            if (gs_ff < ge_ff) begin
               ram_we = 1'b1;
               ram_wa = gs_ff[ADDR_W-1:0];
               ram_wd = ch_ff;
               gs_in  = gs_ff + 1'b1;
               pos_in = ins_step(pos_ff, ch_ff);
            end
            state_in = ret_ff;
         end
         S_MR_A: begin
            if (ge_ff[ADDR_W]) begin
               none_in  = 1'b1;
               state_in = ret_ff;
            end else begin
               none_in  = 1'b0;
               ram_ra   = ge_ff[ADDR_W-1:0];
               state_in = S_MR_B;
            end
         end
         S_MR_B: begin
            if (peek_ff && rd == CH_NL) begin
               none_in = 1'b1;
            end else begin
               ch_in  = rd;
               ge_in  = ge_ff + 1'b1;
               ram_we = 1'b1;
               ram_wa = gs_ff[ADDR_W-1:0];
               ram_wd = rd;
               gs_in  = gs_ff + 1'b1;
               pos_in = ins_step(pos_ff, rd);
            end
            state_in = ret_ff;
         end
         S_RB_A: begin
            if (gs_ff == '0) begin
               none_in  = 1'b1;
               state_in = ret_ff;
            end else begin
               none_in  = 1'b0;
               ram_ra   = ADDR_W'(gs_ff - 1'b1);
               state_in = S_RB_B;
            end
         end
         S_RB_B: begin
            if (peek_ff && rd == CH_NL) begin
               none_in  = 1'b1;
               state_in = ret_ff;
            end else begin
               ch_in     = rd;
               gs_in     = gs_ff - 1'b1;
               pos_in.cc = pos_ff.cc - 1'b1;
               if (ml_ff) begin
                  ram_we = 1'b1;
                  ram_wa = ADDR_W'(ge_ff - 1'b1);
                  ram_wd = rd;
                  ge_in  = ge_ff - 1'b1;
               end
               if (rd == CH_NL || pos_ff.wc == '0) begin
                  if (rd == CH_NL) begin
                     pos_in.lc = pos_ff.lc - 1'b1;
                  end
                  pos_in.wl = pos_ff.wl - 1'b1;
                  rbnl_in   = (rd == CH_NL);
                  scrb_in   = 1'b1;
                  p_in      = gs_ff - 1'b1;
                  dist_in   = '0;
                  mod_in    = '0;
                  run_in    = '0;
                  nonsp_in  = 1'b0;
                  state_in  = S_SC_A;
               end else begin
                  pos_in.wc = pos_ff.wc - 1'b1;
                  state_in  = ret_ff;
               end
            end
         end
         S_SC_A: begin
            if (p_ff == '0) begin
               scan_end = 1'b1;
            end else begin
               ram_ra   = ADDR_W'(p_ff - 1'b1);
               state_in = S_SC_B;
            end
         end
         S_SC_B: begin
            if (rd == CH_NL) begin
               scan_end = 1'b1;
            end else begin
               p_in    = p_ff - 1'b1;
               dist_in = dist_ff + 1'b1;
               mod_in  = (mod_ff == WC_W'(WRAP_WIDTH - 1)) ? '0 : mod_ff + 1'b1;
               if (rd == CH_SP) begin
                  run_in = run_ff + 1'b1;
               end else begin
                  run_in   = '0;
                  nonsp_in = 1'b1;
               end
               state_in = S_SC_A;
            end
         end
         K_RET1: begin
            cnt_in   = run_ff;
            ch_in    = CH_NL;
            ret_in   = K_PAD;
            state_in = S_INS;
         end
         K_TAB1: begin
            cnt_in   = CNT_W'(2'(2'd0 - pos_ff.cc[1:0]));
            state_in = K_PAD;
         end
         K_PAD: begin
            if (cnt_ff == '0) begin
               state_in = K_GOAL;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               ch_in    = CH_SP;
               ret_in   = K_PAD;
               state_in = S_INS;
            end
         end
         K_BS1: begin
            cnt_in   = (nonsp_ff || run_ff == '0) ? CNT_W'(1) : run_ff;
            state_in = K_BS2;
         end
         K_BS2: begin
            cnt_in   = cnt_ff - 1'b1;
            ml_in    = 1'b0;
            peek_in  = 1'b0;
            ret_in   = K_BS3;
            state_in = S_RB_A;
         end
         K_BS3: state_in = (cnt_ff[1:0] != 2'd0) ? K_BS2 : K_GOAL;
         K_DN0: begin
            cnt_in   = CNT_W'(WRAP_WIDTH);
            state_in = K_DN1;
         end
         K_DN1: begin
            cnt_in   = cnt_ff - 1'b1;
            peek_in  = 1'b0;
            ret_in   = K_DN2;
            state_in = S_MR_A;
         end
         K_DN2: begin
            if (none_ff) begin
               state_in = K_GOAL;
            end else if (ch_ff == CH_NL) begin
               cnt_in   = CNT_W'(goal_ff);
               state_in = K_AG1;
            end else if (cnt_ff == '0) begin
               state_in = K_LEND;
            end else begin
               state_in = K_DN1;
            end
         end
         K_UP0: begin
            cnt_in   = CNT_W'(WRAP_WIDTH);
            state_in = K_UP1;
         end
         K_UP1: begin
            cnt_in   = cnt_ff - 1'b1;
            ml_in    = 1'b1;
            peek_in  = 1'b0;
            ret_in   = K_UP2;
            state_in = S_RB_A;
         end
         K_UP2: begin
            if (none_ff) begin
               state_in = K_GOAL;
            end else if (ch_ff == CH_NL) begin
               state_in = K_UP3;
            end else if (cnt_ff == '0) begin
               state_in = K_LEND;
            end else begin
               state_in = K_UP1;
            end
         end
         K_UP3: begin
            if (pos_ff.wc != '0 && gs_ff != '0) begin
               ml_in    = 1'b1;
               peek_in  = 1'b0;
               ret_in   = K_UP3;
               state_in = S_RB_A;
            end else begin
               cnt_in   = CNT_W'(goal_ff);
               state_in = K_AG1;
            end
         end
         K_AG1: begin
            if (cnt_ff == '0) begin
               state_in = K_LEND;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               peek_in  = 1'b1;
               ret_in   = K_AG2;
               state_in = S_MR_A;
            end
         end
         K_AG2: state_in = none_ff ? K_LEND : K_AG1;
         K_LEND: begin
            if (page_ff == PAGE_W'(1)) begin
               state_in = K_GOAL;
            end else begin
               page_in  = page_ff - 1'b1;
               state_in = is_up ? K_UP0 : K_DN0;
            end
         end
         K_HOME: begin
            ml_in    = 1'b1;
            peek_in  = 1'b1;
            ret_in   = K_HOME2;
            state_in = S_RB_A;
         end
         K_HOME2: state_in = none_ff ? K_GOAL : K_HOME;
         K_END: begin
            peek_in  = 1'b1;
            ret_in   = K_END2;
            state_in = S_MR_A;
         end
         K_END2: state_in = none_ff ? K_GOAL : K_END;
         K_GOAL: begin
            if (key_ff != KEY_UP && key_ff != KEY_DOWN) begin
               goal_in = pos_ff.wc;
            end
            state_in = S_FIN;
         end
         default: state_in = S_IDLE;
      endcase

      if (scan_end) begin
         if (scrb_ff) begin
            pos_in.wc = mod_ff;
            if (rbnl_ff) begin
               pos_in.cc = LINE_W'(dist_ff);
            end
         end
         state_in = ret_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gs_ff    <= '0;
         ge_ff    <= PTR_W'(BUF_BYTES);
         pos_ff   <= '0;
         goal_ff  <= '0;
         chg_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         gs_ff    <= gs_in;
         ge_ff    <= ge_in;
         pos_ff   <= pos_in;
         goal_ff  <= goal_in;
         chg_ff   <= chg_in;
      end
      ret_ff    <= ret_in;
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      rpos_ff   <= rpos_in;
      cnt_ff    <= cnt_in;
      page_ff   <= page_in;
      ml_ff     <= ml_in;
      peek_ff   <= peek_in;
      scrb_ff   <= scrb_in;
      rbnl_ff   <= rbnl_in;
      ch_ff     <= ch_in;
      none_ff   <= none_in;
      p_ff      <= p_in;
      dist_ff   <= dist_in;
      run_ff    <= run_in;
      mod_ff    <= mod_in;
      nonsp_ff  <= nonsp_in;
      rbyte_ff  <= rbyte_in;
      rvalid_ff <= rvalid_in;
   end

   assign status.idle = (state_ff == S_IDLE);
   assign status.done = (state_ff == S_FIN);

   assign result.read_byte      = rbyte_ff;
   assign result.read_valid     = rvalid_ff;
   assign result.line_number    = pos_ff.lc;
   assign result.column_number  = pos_ff.cc;
   assign result.wrapped_column = pos_ff.wc;
   assign result.wrapped_line   = pos_ff.wl;
   assign result.free_bytes     = LINE_W'(ge_ff - gs_ff);
   assign result.modified       = chg_ff;

endmodule

// ===== bench/tb_gap_buffer_text_edit_engine_top.sv =====
// Testbench for the gap buffer text edit engine: key, read and clean beats checked against a predictor.
`timescale 1ns / 1ps
module tb_gap_buffer_text_edit_engine_top;
   import gbte_pkg::*;

   localparam int LIMIT_CYCLES = 20000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   gbte_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   gbte_rsp_type rsp_payload;

   gap_buffer_text_edit_engine_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // editor image
   logic [7:0] doc_mem [BUF_BYTES];
   int unsigned gs, ge, ln, col, wcol, wln, goal;
   bit dirty;

   gbte_rsp_type pending_rsp [$];
   int  mismatches = 0;
   longint cycles = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   function automatic int unsigned sol_of(int unsigned p);
      while (p > 0 && doc_mem[p-1] != CH_NL) p--;
      return p;
   endfunction

   function automatic int unsigned byte_left();
      return gs > 0 ? doc_mem[gs-1] : CH_NL;
   endfunction

   function automatic int unsigned byte_right();
      return ge < BUF_BYTES ? doc_mem[ge] : CH_NL;
   endfunction

   function automatic void put_char(logic [7:0] ch);
      if (gs >= ge) return;
      doc_mem[gs] = ch; gs++;
      col++;
      if (ch == CH_NL) begin
         col = 0; ln++; wcol = 0; wln++;
      end else begin
         wcol++;
         if (wcol == WRAP_WIDTH) begin
            wcol = 0; wln++;
         end
      end
   endfunction

   function automatic int take_char();
      int unsigned ch, span;
      if (gs == 0) return -1;
      col--;
      gs--;
      ch = doc_mem[gs];
      if (ch == CH_NL || wcol == 0) begin
         span = gs - sol_of(gs);
         if (ch == CH_NL) begin
            ln--; col = span;
         end
         wcol = span % WRAP_WIDTH;
         wln--;
      end else begin
         wcol--;
      end
      return ch;
   endfunction

   function automatic int step_right();
      logic [7:0] ch;
      if (ge >= BUF_BYTES) return -1;
      ch = doc_mem[ge]; ge++;
      put_char(ch);
      return ch;
   endfunction

   function automatic int step_left();
      int ch;
      ch = take_char();
      if (ch >= 0) begin
         ge--; doc_mem[ge] = ch[7:0];
      end
      return ch;
   endfunction

   function automatic void seek_goal();
      for (int i = 0; i < goal; i++) begin
         if (byte_right() == CH_NL) break;
         void'(step_right());
      end
   endfunction

   function automatic void row_down();
      for (int i = 0; i < WRAP_WIDTH; i++)
         if (step_right() == CH_NL) begin
            seek_goal();
            return;
         end
   endfunction

   function automatic void row_up();
      for (int i = 0; i < WRAP_WIDTH; i++)
         if (step_left() == CH_NL) begin
            while (wcol > 0 && gs > 0) void'(step_left());
            seek_goal();
            return;
         end
   endfunction

   function automatic void apply_key(logic [7:0] key);
      int unsigned i, sp, n, p, indent;
      bit only_sp;
      if (key >= CH_SP && key <= CH_LAST) begin
         put_char(key); dirty = 1;
      end else begin
         case (key)
            KEY_RET: begin
               p = sol_of(gs); indent = 0;
               while (p < gs && doc_mem[p] == CH_SP) begin
                  indent++; p++;
               end
               put_char(CH_NL);
               repeat (indent) put_char(CH_SP);
               dirty = 1;
            end
            KEY_BS: begin
               i = gs; sp = 0; only_sp = 1;
               while (i > 0) begin
                  if (doc_mem[i-1] == CH_NL) break;
                  if (doc_mem[i-1] != CH_SP) begin
                     only_sp = 0;
                     break;
                  end
                  sp++; i--;
               end
               if (!only_sp || sp < 1) sp = 1;
               do begin
                  void'(take_char()); sp--;
               end while (sp % 4 != 0);
               dirty = 1;
            end
            KEY_DEL: begin
               if (ge < BUF_BYTES) ge++;
               dirty = 1;
            end
            KEY_TAB: begin
               put_char(CH_SP);
               n = (4 - col) & 3;
               repeat (n) put_char(CH_SP);
               dirty = 1;
            end
            KEY_RIGHT: void'(step_right());
            KEY_LEFT:  void'(step_left());
            KEY_DOWN:  row_down();
            KEY_UP:    row_up();
            KEY_HOME:  while (byte_left() != CH_NL) void'(step_left());
            KEY_END:   while (byte_right() != CH_NL) void'(step_right());
            KEY_PGDN:  for (i = 0; i + 1 < PAGE_LINES; i++) row_down();
            KEY_PGUP:  for (i = 0; i + 1 < PAGE_LINES; i++) row_up();
            default: ;
         endcase
      end
      if (key != KEY_UP && key != KEY_DOWN) goal = wcol;
   endfunction

   function automatic gbte_rsp_type predict_edit(gbte_req_type rq);
      gbte_rsp_type r;
      int unsigned len;
      r = '0;
      if (rq.kind == KIND_KEY) apply_key(rq.key_code);
      else if (rq.kind == KIND_READ) begin
         len = gs + (BUF_BYTES - ge);
         if (rq.read_position < len) begin
            r.read_byte = rq.read_position < gs ? doc_mem[rq.read_position]
                                                : doc_mem[ge + (rq.read_position - gs)];
            r.read_valid = 1'b1;
         end else begin
            r.read_byte = CH_NL;
         end
      end else if (rq.kind == KIND_CLEAN) dirty = 0;
      r.line_number    = ln[LINE_W-1:0];
      r.column_number  = col[LINE_W-1:0];
      r.wrapped_column = wcol[WC_W-1:0];
      r.wrapped_line   = wln[LINE_W-1:0];
      r.free_bytes     = LINE_W'(ge - gs);
      r.modified       = dirty;
      return r;
   endfunction

   task automatic send_beat(logic [1:0] kind, logic [7:0] key, logic [POS_W-1:0] pos);
      gbte_req_type rq;
      rq.kind = kind; rq.key_code = key; rq.read_position = pos;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_payload <= rq;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(predict_edit(rq));
   endtask

   task automatic press(logic [7:0] key);
      send_beat(KIND_KEY, key, POS_W'($urandom_range(8191)));
   endtask

   task automatic read_at(int unsigned pos);
      send_beat(KIND_READ, 8'($urandom_range(255)), pos[POS_W-1:0]);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset)
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", rsp_payload);
         end else begin
            if (rsp_payload !== pending_rsp[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", pending_rsp[0], rsp_payload);
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   function automatic logic [7:0] rand_key();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return 8'($urandom_range(CH_SP, CH_LAST));
      if (r < 50) return KEY_RET;
      if (r < 56) return KEY_BS;
      if (r < 60) return KEY_TAB;
      if (r < 64) return KEY_DEL;
      if (r < 70) return KEY_LEFT;
      if (r < 76) return KEY_RIGHT;
      if (r < 81) return KEY_UP;
      if (r < 86) return KEY_DOWN;
      if (r < 89) return KEY_HOME;
      if (r < 92) return KEY_END;
      if (r < 94) return KEY_PGUP;
      if (r < 96) return KEY_PGDN;
      return 8'($urandom_range(255));
   endfunction

   task automatic test_directed_edits();
      read_at(0);
      press(8'd126); press(8'd32); press(KEY_BS); press(KEY_BS); press(KEY_BS);
      press(KEY_TAB); press(KEY_TAB); press(8'd65); press(KEY_RET);
      press(KEY_BS); press(KEY_BS); press(KEY_HOME); press(KEY_DEL);
      press(KEY_END); press(KEY_DEL); press(KEY_UP); press(KEY_DOWN);
      press(KEY_LEFT); press(KEY_RIGHT); press(KEY_PGUP); press(KEY_PGDN);
      press(8'd0); press(8'd255);
      send_beat(KIND_CLEAN, 8'd0, 13'h1FFF);
      send_beat(2'd3, 8'hFF, 13'h1FFF);
      read_at(8191); read_at(1);
   endtask

   task automatic test_wrap_and_indent();
      repeat (80) press(8'($urandom_range(CH_SP, CH_LAST)));
      press(KEY_HOME); press(KEY_TAB); press(KEY_RET); press(KEY_RET);
      repeat (6) press(8'd32);
      press(KEY_RET); press(KEY_BS); press(KEY_UP); press(KEY_UP); press(KEY_DOWN);
      drain_results();
   endtask

   task automatic test_random_phase(int n, int idle, int stall);
      send_idle_pct = idle; recv_stall_pct = stall;
      repeat (n) begin
         case ($urandom_range(9))
            0: read_at($urandom_range(gs + BUF_BYTES - ge + 2));
            1: if ($urandom_range(3) == 0) send_beat(KIND_CLEAN, 8'($urandom_range(255)),
                                                     POS_W'($urandom_range(8191)));
               else read_at($urandom_range(8191));
            default: press(rand_key());
         endcase
      end
      drain_results();
   endtask

   task automatic test_full_gap();
      send_idle_pct = 0; recv_stall_pct = 0;
      // a wide run of leading spaces makes each return copy up to two hundred bytes of indent
      press(KEY_RET);
      repeat (50) press(KEY_TAB);
      while (gs < ge) press(KEY_RET);
      press(8'd66); press(KEY_TAB); press(KEY_RET);
      read_at(8191); read_at(0);
      press(KEY_PGUP); press(KEY_PGDN); press(KEY_HOME); press(KEY_BS);
      drain_results();
   endtask

   initial begin
      gs = 0; ge = BUF_BYTES; ln = 0; col = 0; wcol = 0; wln = 0; goal = 0; dirty = 1;
      for (int i = 0; i < BUF_BYTES; i++) doc_mem[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edits();
      test_wrap_and_indent();
      test_random_phase(60, 0, 0);
      test_random_phase(60, 71, 0);
      test_random_phase(60, 0, 71);
      test_random_phase(60, 15, 15);
      test_full_gap();
      send_idle_pct = 0; recv_stall_pct = 0;
      drain_results();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
